>>> hw/rtl/stir2_pkg.sv
// ----------------------------------------------------------------------------
// stir2_pkg
// Shared widths, reset values and register codes of the Stirling row engine.
// ----------------------------------------------------------------------------
package stir2_pkg;

	localparam int ROW_W       = 32;
	localparam int COL_W       = 6;
	localparam int VAL_W       = 31;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 31;
	localparam int CNT_W       = 5;

	localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(998244353);
	localparam logic [COL_W-1:0] COL_RESET = COL_W'(63);
	localparam logic [ROW_W-1:0] ROW_MAX   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS   = 1'b0,
		REG_COL_LIMIT = 1'b1
	} cfg_reg_t;

endpackage

>>> hw/rtl/stirling_second_kind_rows_top.sv
// ----------------------------------------------------------------------------
// stirling_second_kind_rows_top
// Stirling numbers of the second kind modulo p, one triangle row per input word.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata[0] restart
// m_axis    out  m_axis_tvalid/tready    tdata row, col, value; tlast end of row
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One shared compare-subtract unit does all modular arithmetic under a sequencer.
// Row 0 emits its single entry directly; a later row reads and checks column 0, then for
// each further column multiplies the stored entry by the column index through repeated
// doubling and adding, with a bit-serial reduction of any stored entry not below the modulus.
// Reset clears the row counter and the fill count; the row store needs no clearing.
// A stalled output word holds the sequencer only when the next word is ready.
// ----------------------------------------------------------------------------
module stirling_second_kind_rows_top #(
	parameter int MAX_COLS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [stir2_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] restart, [7:1] zero
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [stir2_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] row_index,
	                                                         // [37:32] col_index,
	                                                         // [68:38] value, [71:69] zero
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [stir2_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stir2_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import stir2_pkg::*;

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int LW = $clog2(MAX_COLS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CHK, S_RED, S_DBL, S_ADDB, S_SUMA, S_PUT
	} state_t;

	state_t             state_q;
	logic [VAL_W-1:0]   modulus_q;
	logic [COL_W-1:0]   col_limit_q;
	logic [ROW_W-1:0]   next_row_q;
	logic [ROW_W-1:0]   row_q;
	logic [LW-1:0]      prev_len_q;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      lastcol_q;
	logic [AW-1:0]      fetch_addr_q;
	logic               dst_a_q;
	logic [VAL_W-1:0]   a_q;
	logic [VAL_W-1:0]   b_q;
	logic [VAL_W-1:0]   t_q;
	logic [VAL_W-1:0]   r_q;
	logic [VAL_W-1:0]   red_x_q;
	logic [VAL_W-1:0]   val_q;
	logic [VAL_W-1:0]   rdata_q;
	logic [AW-1:0]      jsh_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic               out_last_q;

	logic [VAL_W-1:0]   mem [MAX_COLS];

	logic [ROW_W:0]     m_eff;
	logic [VAL_W-1:0]   one_val;
	logic [AW-1:0]      k_eff;
	logic [ROW_W-1:0]   row_in;
	logic [AW-1:0]      lastcol_in;
	logic [ROW_W-1:0]   chk_x;
	logic [ROW_W-1:0]   ux;
	logic [ROW_W:0]     udiff;
	logic               uge;
	logic [VAL_W-1:0]   ures;
	logic               fin;
	logic [VAL_W-1:0]   fin_val;
	logic               in_acc;
	logic               out_free;
	logic               put_go;
	logic [AW-1:0]      jn;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MOD_RESET;
			col_limit_q <= COL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODULUS:   modulus_q   <= cfg_data;
				REG_COL_LIMIT: col_limit_q <= cfg_data[COL_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		m_eff   = (modulus_q == '0) ? (ROW_W+1)'(33'h0_8000_0000) : (ROW_W+1)'(modulus_q);
		one_val = (modulus_q == VAL_W'(1)) ? '0 : VAL_W'(1);
		k_eff   = (col_limit_q > COL_W'(MAX_COLS - 1)) ? AW'(MAX_COLS - 1)
		                                                : col_limit_q[AW-1:0];
		row_in  = s_axis_tdata[0] ? '0 : next_row_q;
		if (row_in == '0)
			lastcol_in = '0;
		else if (row_in <= ROW_W'(k_eff))
			lastcol_in = row_in[AW-1:0];
		else
			lastcol_in = k_eff;
		in_acc   = s_axis_tvalid && s_axis_tready;
		out_free = !out_valid_q || m_axis_tready;
		put_go   = (state_q == S_PUT) && out_free;
		jn       = j_q + AW'(1);
		chk_x    = (LW'(fetch_addr_q) < prev_len_q) ? {1'b0, rdata_q} : '0;
	end

	// shared compare-subtract unit
	always_comb begin
		case (state_q)
			S_CHK:   ux = chk_x;
			S_RED:   ux = {r_q, red_x_q[VAL_W-1]};
			S_DBL:   ux = {t_q, 1'b0};
			S_ADDB:  ux = jsh_q[AW-1] ? ({1'b0, t_q} + {1'b0, b_q}) : {1'b0, t_q};
			S_SUMA:  ux = {1'b0, a_q} + {1'b0, t_q};
			default: ux = '0;
		endcase
		udiff   = {1'b0, ux} - m_eff;
		uge     = !udiff[ROW_W];
		ures    = uge ? udiff[VAL_W-1:0] : ux[VAL_W-1:0];
		fin     = ((state_q == S_CHK) && !uge) || ((state_q == S_RED) && (cnt_q == '0));
		fin_val = (state_q == S_CHK) ? ux[VAL_W-1:0] : ures;
	end

	always_ff @(posedge clk) begin
		if (put_go)
			mem[j_q] <= val_q;
		rdata_q <= mem[fetch_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_row_q  <= '0;
			prev_len_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready && !put_go)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						row_q        <= row_in;
						next_row_q   <= (row_in == ROW_MAX) ? row_in : row_in + ROW_W'(1);
						lastcol_q    <= lastcol_in;
						j_q          <= '0;
						fetch_addr_q <= '0;
						dst_a_q      <= 1'b1;
						if (row_in == '0) begin
							val_q   <= one_val;
							state_q <= S_PUT;
						end else begin
							val_q   <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK, S_RED: begin
					if (fin) begin
						if (dst_a_q) begin
							a_q     <= fin_val;
							state_q <= S_PUT;
						end else begin
							b_q     <= fin_val;
							t_q     <= '0;
							jsh_q   <= j_q;
							cnt_q   <= CNT_W'(AW - 1);
							state_q <= S_DBL;
						end
					end else if (state_q == S_CHK) begin
						red_x_q <= ux[VAL_W-1:0];
						r_q     <= '0;
						cnt_q   <= CNT_W'(VAL_W - 1);
						state_q <= S_RED;
					end else begin
						r_q     <= ures;
						red_x_q <= red_x_q << 1;
						cnt_q   <= cnt_q - CNT_W'(1);
					end
				end
				S_DBL: begin
					t_q     <= ures;
					state_q <= S_ADDB;
				end
				S_ADDB: begin
					t_q   <= ures;
					jsh_q <= jsh_q << 1;
					cnt_q <= cnt_q - CNT_W'(1);
					state_q <= (cnt_q == '0) ? S_SUMA : S_DBL;
				end
				S_SUMA: begin
					val_q   <= ures;
					a_q     <= b_q;
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {3'b000, val_q, COL_W'(j_q), row_q};
						out_last_q  <= (j_q == lastcol_q);
						if (j_q == lastcol_q) begin
							prev_len_q <= LW'(lastcol_q) + LW'(1);
							state_q    <= S_IDLE;
						end else begin
							j_q <= jn;
							if (row_q == ROW_W'(jn)) begin
								val_q <= one_val;
							end else begin
								fetch_addr_q <= jn;
								dst_a_q      <= 1'b0;
								state_q      <= S_RD;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prev_len_q <= LW'(MAX_COLS))
		else $error("fill count beyond row store");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (j_q <= lastcol_q))
		else $error("column past end of row");

	a_val_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> ((ROW_W+1)'(val_q) < m_eff))
		else $error("entry not reduced");

	a_restart_row: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tdata[0]) |=> (next_row_q == ROW_W'(1)))
		else $error("restart did not reset row counter");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(put_go && (j_q == lastcol_q)) |=> (state_q == S_IDLE))
		else $error("sequencer busy after last word");

endmodule
